[src/normalized_line_hash_macros.svh]
// Assertion macros used by the checker of the line hash block.
`ifndef NORMALIZED_LINE_HASH_MACROS_SVH
`define NORMALIZED_LINE_HASH_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define NLH_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication that is also checked while reset is high.
`define NLH_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) (cond) |=> (prop)) else $error(msg);

`endif

[src/nlh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlh_pkg
// Types and character constants shared by the line hash block.
// ----------------------------------------------------------------------------
package nlh_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_DROP_ALL_SPACE = 2'd0,
    REG_COLLAPSE_SPACE = 2'd1,
    REG_FOLD_CASE      = 2'd2,
    REG_SQUASH_DIGITS  = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic drop_all_space;
    logic collapse_space;
    logic fold_case;
    logic squash_digits;
  } cfg_t;

  // Class of the run the last hashed character belongs to.
  typedef enum logic [1:0] {
    RUN_NONE   = 2'd0,
    RUN_SPACE  = 2'd1,
    RUN_NUMBER = 2'd2
  } run_class_t;

  // Normalizer decision for one character.
  typedef struct packed {
    logic       take;
    logic [7:0] code;
    run_class_t run_class;
    logic       newline_seen;
  } norm_t;

  localparam int unsigned HASH_SHIFT   = 7;
  localparam int unsigned OUT_W        = 32;

  localparam logic [7:0] CHAR_NUL      = 8'h00;
  localparam logic [7:0] CHAR_TAB      = 8'h09;
  localparam logic [7:0] CHAR_NL       = 8'h0A;
  localparam logic [7:0] CHAR_CR       = 8'h0D;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_NINE     = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;

endpackage

[src/nlh_norm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlh_norm
// Applies the enabled ignore rules to one character and gives the code to
// hash, whether to hash it, and the run state that follows.
// ----------------------------------------------------------------------------
module nlh_norm (
  input  logic [7:0]         char_code,
  input  nlh_pkg::cfg_t      cfg,
  input  nlh_pkg::run_class_t run_class,
  input  logic               newline_seen,
  output nlh_pkg::norm_t     norm
);
  import nlh_pkg::*;

  logic is_space;
  logic is_digit;
  logic is_upper;
  logic is_stop;

  assign is_space = (char_code == CHAR_SPACE) ||
                    ((char_code >= CHAR_TAB) && (char_code <= CHAR_CR));
  assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
  assign is_upper = (char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_Z);
  assign is_stop  = (char_code == CHAR_NL) || (char_code == CHAR_NUL);

  always_comb begin
    norm.take         = 1'b0;
    norm.code         = char_code;
    norm.run_class    = run_class;
    norm.newline_seen = newline_seen;
    // Rule order: end of text, whitespace rules, digit rule, case folding.
    priority if (newline_seen) begin
      norm.take = 1'b0;
    end else if (is_stop) begin
      norm.newline_seen = 1'b1;
    end else if (is_space) begin
      priority if (cfg.drop_all_space) begin
        norm.take = 1'b0;
      end else if (cfg.collapse_space && (run_class == RUN_SPACE)) begin
        norm.take = 1'b0;
      end else begin
        norm.take      = 1'b1;
        norm.code      = cfg.collapse_space ? CHAR_SPACE : char_code;
        norm.run_class = RUN_SPACE;
      end
    end else if (cfg.squash_digits && is_digit) begin
      norm.take      = (run_class != RUN_NUMBER);
      norm.code      = CHAR_ZERO;
      norm.run_class = RUN_NUMBER;
    end else begin
      norm.take      = 1'b1;
      norm.code      = (cfg.fold_case && is_upper) ? (char_code + CASE_OFFSET) : char_code;
      norm.run_class = RUN_NONE;
    end
  end

endmodule

[src/normalized_line_hash.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normalized_line_hash
// Hashes a line one character per word into a raw and a normalized hash.
// ----------------------------------------------------------------------------
// One character word is taken every cycle unless char_stall is high. A word
// sits in the input register and is then folded by a single shift-add
// (acc*129 + char) into the raw accumulator and, if the rules take it, into
// the normalized one; a line-end word then moves its hashes into the result
// register. If the result register is still held by hash_stall, a line-end
// word waits in the input register and char_stall rises until the result is
// taken. The four rule registers are written over the cfg port, one bit each,
// always ready; write them only while no line is in flight.
module normalized_line_hash #(
  parameter int unsigned HASH_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  nlh_pkg::cfg_index_t cfg_index,
  input  logic               cfg_data,
  input  logic               char_valid,
  output logic               char_stall,
  input  logic [7:0]         char_code,
  input  logic               no_char,
  input  logic               line_end,
  output logic               hash_valid,
  input  logic               hash_stall,
  output logic [31:0]        line_hash,
  output logic [31:0]        raw_hash
);
  import nlh_pkg::*;

  cfg_t                 cfg;
  run_class_t           run_class;
  logic                 newline_seen;
  logic [HASH_BITS-1:0] raw_acc;
  logic [HASH_BITS-1:0] norm_acc;

  logic                 s1_valid;
  logic [7:0]           s1_char;
  logic                 s1_no_char;
  logic                 s1_line_end;

  logic                 out_free;
  logic                 s1_go;
  logic                 char_take;
  norm_t                norm;
  logic [HASH_BITS-1:0] raw_code;
  logic [HASH_BITS-1:0] raw_acc_next;
  logic [HASH_BITS-1:0] norm_acc_next;
  logic [HASH_BITS-1:0] line_sel;
  logic                 any_rule;

  assign cfg_ready  = 1'b1;
  assign out_free   = !hash_valid || !hash_stall;
  assign s1_go      = s1_valid && (!s1_line_end || out_free);
  assign char_stall = s1_valid && !s1_go;
  assign char_take  = char_valid && !char_stall;

  nlh_norm u_norm (
    .char_code    (s1_char),
    .cfg          (cfg),
    .run_class    (run_class),
    .newline_seen (newline_seen),
    .norm         (norm)
  );

  // The raw hash takes the byte sign-extended.
  assign raw_code = {{(HASH_BITS-8){s1_char[7]}}, s1_char};

  always_comb begin
    raw_acc_next  = raw_acc;
    norm_acc_next = norm_acc;
    if (!s1_no_char) begin
      raw_acc_next = raw_acc + (raw_acc << HASH_SHIFT) + raw_code;
      if (norm.take) begin
        norm_acc_next = norm_acc + (norm_acc << HASH_SHIFT) +
                        HASH_BITS'(norm.code);
      end
    end
  end

  assign any_rule = cfg.drop_all_space || cfg.collapse_space ||
                    cfg.fold_case || cfg.squash_digits;
  assign line_sel = any_rule ? norm_acc_next : raw_acc_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DROP_ALL_SPACE: cfg.drop_all_space <= cfg_data;
        REG_COLLAPSE_SPACE: cfg.collapse_space <= cfg_data;
        REG_FOLD_CASE:      cfg.fold_case      <= cfg_data;
        REG_SQUASH_DIGITS:  cfg.squash_digits  <= cfg_data;
      endcase
    end
  end

  // Control state and line state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      hash_valid   <= 1'b0;
      raw_acc      <= '0;
      norm_acc     <= '0;
      run_class    <= RUN_SPACE;
      newline_seen <= 1'b0;
    end else begin
      if (char_take) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end

      if (s1_go && s1_line_end) begin
        hash_valid <= 1'b1;
      end else if (!hash_stall) begin
        hash_valid <= 1'b0;
      end

      if (s1_go) begin
        if (s1_line_end) begin
          raw_acc      <= '0;
          norm_acc     <= '0;
          run_class    <= RUN_SPACE;
          newline_seen <= 1'b0;
        end else begin
          raw_acc  <= raw_acc_next;
          norm_acc <= norm_acc_next;
          if (!s1_no_char) begin
            run_class    <= norm.run_class;
            newline_seen <= norm.newline_seen;
          end
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (char_take) begin
      s1_char     <= char_code;
      s1_no_char  <= no_char;
      s1_line_end <= line_end;
    end
    if (s1_go && s1_line_end) begin
      line_hash <= OUT_W'(line_sel);
      raw_hash  <= OUT_W'(raw_acc_next);
    end
  end

endmodule

[src/nlh_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlh_checker
// Port-level checks of the line hash block, bound to its top level.
// ----------------------------------------------------------------------------
`include "normalized_line_hash_macros.svh"

module nlh_checker (
  input logic        clk,
  input logic        rst,
  input logic        char_valid,
  input logic        char_stall,
  input logic        line_end,
  input logic        hash_valid,
  input logic        hash_stall,
  input logic [31:0] line_hash,
  input logic [31:0] raw_hash
);

  // A stalled result word keeps its value.
  `NLH_ASSERT_NEXT(a_result_hold, !rst && hash_valid && hash_stall, rst || (hash_valid && $stable(line_hash) && $stable(raw_hash)), "result changed while stalled")

  // Reset empties both the input and the result side.
  `NLH_ASSERT_NEXT(a_reset_empty, rst, !hash_valid && !char_stall, "block not empty after reset")

  // Input only backs up behind a result word that is itself stalled.
  `NLH_ASSERT_IMPL(a_stall_cause, char_stall, hash_valid && hash_stall, "input stalled with free result")

  // A fresh result follows a line-end word that was taken.
  `NLH_ASSERT_IMPL(a_result_source, $rose(hash_valid), $past(char_valid && !char_stall && line_end, 2), "result without line end")

endmodule

bind normalized_line_hash nlh_checker u_nlh_checker (
  .clk        (clk),
  .rst        (rst),
  .char_valid (char_valid),
  .char_stall (char_stall),
  .line_end   (line_end),
  .hash_valid (hash_valid),
  .hash_stall (hash_stall),
  .line_hash  (line_hash),
  .raw_hash   (raw_hash)
);
